// File: src/alirs_pkg.sv
// Shared types and constants for the ambient light I2C readout sequencer.
`default_nettype none

package alirs_pkg;

  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 20;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned RawW        = 16;
  localparam int unsigned WaitW       = 20;
  localparam int unsigned WaitBitsDef = 20;

  // floor(x / 6) equals (x * LuxRecip) >> LuxShift for every x below 2**19,
  // and the factor 5 is folded into LuxMul.
  localparam int unsigned LuxShift = 21;
  localparam int unsigned LuxMulW  = 21;
  localparam int unsigned ProdW    = RawW + LuxMulW;
  localparam logic [LuxMulW-1:0] LuxRecip = LuxMulW'(((1 << LuxShift) + 5) / 6);
  localparam logic [LuxMulW-1:0] LuxMul   = LuxMulW'(5 * (((1 << LuxShift) + 5) / 6));

  localparam logic [ByteW-1:0] DevAddrRst = 8'd70;
  localparam logic [ByteW-1:0] PwrCmdRst  = 8'd1;
  localparam logic [ByteW-1:0] ModeCmdRst = 8'd16;
  localparam logic [WaitW-1:0] WaitRst    = 20'd36000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDevAddr = 2'd0,
    CfgPwrCmd  = 2'd1,
    CfgModeCmd = 2'd2,
    CfgWait    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] dev_addr;
    logic [ByteW-1:0] pwr_cmd;
    logic [ByteW-1:0] mode_cmd;
    logic [WaitW-1:0] wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic            clock_line;
    logic            data_line_out;
    logic            data_line_input;
    logic            busy_res;
    logic            done_res;
    logic [RawW-1:0] raw_count;
    logic [RawW-1:0] lux;
  } res_t;

endpackage

`default_nettype wire

// File: src/alirs_if.sv
// Handshake interfaces for the tick input, result output and register write channels.
`default_nettype none

interface alirs_in_if;
  logic valid;
  logic ready;
  logic start_request;
  logic sda_level;

  modport source (output valid, output start_request, output sda_level, input ready);
  modport sink (input valid, input start_request, input sda_level, output ready);
endinterface

interface alirs_out_if;
  import alirs_pkg::*;
  logic            valid;
  logic            ready;
  logic            clock_line;
  logic            data_line_out;
  logic            data_line_input;
  logic            busy_res;
  logic            done_res;
  logic [RawW-1:0] raw_count;
  logic [RawW-1:0] lux;

  modport source (output valid, output clock_line, output data_line_out,
                  output data_line_input, output busy_res, output done_res,
                  output raw_count, output lux, input ready);
  modport sink (input valid, input clock_line, input data_line_out,
                input data_line_input, input busy_res, input done_res,
                input raw_count, input lux, output ready);
endinterface

interface alirs_cfg_if;
  import alirs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/alirs_cfg_regs.sv
// Configuration register file written through the register write channel.
`default_nettype none

module alirs_cfg_regs (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  alirs_cfg_if.sink           cfg_i,
  output alirs_pkg::cfg_t     cfg_o
);
  import alirs_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgDevAddr: cfg_d.dev_addr   = cfg_i.data[ByteW-1:0];
        CfgPwrCmd:  cfg_d.pwr_cmd    = cfg_i.data[ByteW-1:0];
        CfgModeCmd: cfg_d.mode_cmd   = cfg_i.data[ByteW-1:0];
        CfgWait:    cfg_d.wait_ticks = cfg_i.data[WaitW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr   <= DevAddrRst;
      cfg_q.pwr_cmd    <= PwrCmdRst;
      cfg_q.mode_cmd   <= ModeCmdRst;
      cfg_q.wait_ticks <= WaitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: src/alirs_lux.sv
// Converts a raw sensor count to lux as floor(raw * 5 / 6) by a reciprocal multiply.
`default_nettype none

module alirs_lux (
  input  wire logic [alirs_pkg::RawW-1:0] raw_i,
  output logic      [alirs_pkg::RawW-1:0] lux_o
);
  import alirs_pkg::*;

  logic [ProdW-1:0] prod;

  assign prod  = ProdW'(raw_i) * ProdW'(LuxMul);
  assign lux_o = prod[LuxShift +: RawW];

endmodule

`default_nettype wire

// File: src/alirs_seq.sv
// Bus sequencer: advances the I2C waveform by one tick per processed transaction.
`default_nettype none

module alirs_seq #(
  parameter int unsigned WaitCounterBits = alirs_pkg::WaitBitsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_en_i,
  input  wire logic            req_i,
  input  wire logic            sda_i,
  input  wire alirs_pkg::cfg_t cfg_i,
  output alirs_pkg::res_t      res_o
);
  import alirs_pkg::*;

  typedef enum logic [14:0] {
    PhIdle   = 15'b000000000000001,
    PhStart1 = 15'b000000000000010,
    PhAddr1  = 15'b000000000000100,
    PhPwr    = 15'b000000000001000,
    PhStop1  = 15'b000000000010000,
    PhStart2 = 15'b000000000100000,
    PhAddr2  = 15'b000000001000000,
    PhMode   = 15'b000000010000000,
    PhStop2  = 15'b000000100000000,
    PhWait   = 15'b000001000000000,
    PhStart3 = 15'b000010000000000,
    PhAddrR  = 15'b000100000000000,
    PhRead   = 15'b001000000000000,
    PhStop3  = 15'b010000000000000,
    PhTail   = 15'b100000000000000
  } phase_e;

  typedef struct packed {
    phase_e           phase;
    logic [3:0]       bit_cnt;
    logic             half;
    logic [ByteW-1:0] shift;
    logic             byte_cnt;
  } enter_t;

  localparam logic [3:0] LastBit = 4'd8;

  phase_e                     phase_q, phase_d;
  logic [3:0]                 bit_q, bit_d;
  logic                       byte_q, byte_d;
  logic                       half_q, half_d;
  logic [ByteW-1:0]           shift_q, shift_d;
  logic [ByteW-1:0]           first_q, first_d;
  logic [WaitCounterBits-1:0] wait_q, wait_d;
  logic [RawW-1:0]            raw_q, raw_d;
  logic [RawW-1:0]            lux_q, lux_d;
  logic [RawW-1:0]            raw_new;
  logic [RawW-1:0]            lux_new;
  logic [WaitCounterBits-1:0] wait_load;

  function automatic enter_t enter_f(phase_e ph, logic [ByteW-1:0] sh, logic bcnt,
                                     cfg_t c);
    enter_t e;
    e.phase    = ph;
    e.bit_cnt  = '0;
    e.half     = 1'b0;
    e.shift    = sh;
    e.byte_cnt = bcnt;
    case (ph)
      PhAddr1, PhAddr2: e.shift = c.dev_addr;
      PhPwr:            e.shift = c.pwr_cmd;
      PhMode:           e.shift = c.mode_cmd;
      PhAddrR:          e.shift = c.dev_addr + 8'd1;
      PhRead: begin
        e.shift    = '0;
        e.byte_cnt = 1'b0;
      end
      default: e.phase = ph;
    endcase
    return e;
  endfunction

  assign raw_new   = {first_q, shift_q};
  assign wait_load = WaitCounterBits'(cfg_i.wait_ticks);

  alirs_lux u_lux (
    .raw_i (raw_new),
    .lux_o (lux_new)
  );

  always_comb begin
    phase_e     ph;
    phase_e     nx;
    logic       hf;
    logic [3:0] bc;
    logic [3:0] bc_inc;
    logic       two_step;
    logic       do_enter;
    phase_e     enter_ph;
    enter_t     e;

    ph = phase_q;
    hf = half_q;
    bc = bit_q;
    if (phase_q == PhIdle && req_i) begin
      ph = PhStart1;
      hf = 1'b0;
      bc = '0;
    end
    bc_inc   = bc + 4'd1;
    nx       = PhIdle;
    two_step = 1'b0;
    do_enter = 1'b0;
    enter_ph = PhIdle;

    phase_d = ph;
    bit_d   = bc;
    half_d  = hf;
    byte_d  = byte_q;
    shift_d = shift_q;
    first_d = first_q;
    wait_d  = wait_q;
    raw_d   = raw_q;
    lux_d   = lux_q;

    res_o                 = '0;
    res_o.clock_line      = 1'b1;
    res_o.data_line_out   = 1'b1;
    res_o.busy_res        = 1'b1;

    case (ph)
      PhIdle: res_o.busy_res = 1'b0;
      PhStart1, PhStart2, PhStart3: begin
        res_o.data_line_out = ~hf;
        two_step = 1'b1;
        case (ph)
          PhStart1: nx = PhAddr1;
          PhStart2: nx = PhAddr2;
          default:  nx = PhAddrR;
        endcase
      end
      PhStop1, PhStop2, PhStop3: begin
        res_o.data_line_out = hf;
        two_step = 1'b1;
        case (ph)
          PhStop1: nx = PhStart2;
          PhStop2: nx = PhWait;
          default: nx = PhTail;
        endcase
      end
      PhAddr1, PhPwr, PhAddr2, PhMode, PhAddrR: begin
        res_o.clock_line = ~hf;
        if (bc < LastBit) begin
          res_o.data_line_out = shift_q[ByteW-1];
        end else begin
          res_o.data_line_input = 1'b1;
        end
        if (!hf) begin
          half_d = 1'b1;
        end else begin
          half_d  = 1'b0;
          shift_d = {shift_q[ByteW-2:0], 1'b0};
          bit_d   = bc_inc;
          if (bc_inc > LastBit) begin
            do_enter = 1'b1;
            case (ph)
              PhAddr1: enter_ph = PhPwr;
              PhPwr:   enter_ph = PhStop1;
              PhAddr2: enter_ph = PhMode;
              PhMode:  enter_ph = PhStop2;
              default: enter_ph = PhRead;
            endcase
          end
        end
      end
      PhWait: begin
        wait_d = wait_q - WaitCounterBits'(1);
        if (wait_d == '0) begin
          do_enter = 1'b1;
          enter_ph = PhStart3;
        end
      end
      PhRead: begin
        res_o.clock_line = ~hf;
        if (bc < LastBit) begin
          res_o.data_line_input = 1'b1;
          if (!hf) begin
            shift_d = {shift_q[ByteW-2:0], sda_i};
          end
        end else begin
          res_o.data_line_out = byte_q;
        end
        if (!hf) begin
          half_d = 1'b1;
        end else begin
          half_d = 1'b0;
          bit_d  = bc_inc;
          if (bc_inc > LastBit) begin
            bit_d = '0;
            if (!byte_q) begin
              first_d = shift_q;
              shift_d = '0;
              byte_d  = 1'b1;
            end else begin
              raw_d    = raw_new;
              lux_d    = lux_new;
              byte_d   = 1'b0;
              do_enter = 1'b1;
              enter_ph = PhStop3;
            end
          end
        end
      end
      PhTail: begin
        res_o.done_res = 1'b1;
        do_enter = 1'b1;
        enter_ph = PhIdle;
      end
      default: begin
        res_o.busy_res = 1'b0;
        do_enter = 1'b1;
        enter_ph = PhIdle;
      end
    endcase

    if (two_step) begin
      if (!hf) begin
        half_d = 1'b1;
      end else if (nx == PhWait) begin
        wait_d   = wait_load;
        do_enter = 1'b1;
        enter_ph = (wait_load == '0) ? PhStart3 : PhWait;
      end else begin
        do_enter = 1'b1;
        enter_ph = nx;
      end
    end

    if (do_enter) begin
      e       = enter_f(enter_ph, shift_d, byte_d, cfg_i);
      phase_d = e.phase;
      bit_d   = e.bit_cnt;
      half_d  = e.half;
      shift_d = e.shift;
      byte_d  = e.byte_cnt;
    end

    res_o.raw_count = raw_d;
    res_o.lux       = lux_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      bit_q   <= '0;
      byte_q  <= 1'b0;
      half_q  <= 1'b0;
      shift_q <= '0;
      first_q <= '0;
      wait_q  <= '0;
      raw_q   <= '0;
      lux_q   <= '0;
    end else if (step_en_i) begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      half_q  <= half_d;
      shift_q <= shift_d;
      first_q <= first_d;
      wait_q  <= wait_d;
      raw_q   <= raw_d;
      lux_q   <= lux_d;
    end
  end

endmodule

`default_nettype wire

// File: src/ambient_light_i2c_readout_sequencer.sv
// Top level of the ambient light sensor I2C readout sequencer.
//
// Each transaction on in_i is one bus tick (one 5 us half period) carrying the
// start request and the sampled data line level. Each tick yields exactly one
// transaction on out_o with the clock and data line levels to drive, the busy
// and done flags and the last raw count and lux value.
// A tick is captured in an input register, processed by the sequencer once the
// output register can take its result, and lands in the output register.
// One tick is accepted every cycle while the receiver does not stall.
// When the receiver stalls, the result is held in the output register while
// one more tick waits in the input register; ready drops only when both are
// full. Register writes on cfg_i are taken in any cycle, one per cycle, and
// should be made while no sequence is running.
// Reset returns the sequencer to idle, loads the default register values,
// clears the raw and lux results and empties both registers.
`default_nettype none

module ambient_light_i2c_readout_sequencer #(
  parameter int unsigned WaitCounterBits = alirs_pkg::WaitBitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  alirs_in_if.sink   in_i,
  alirs_out_if.source out_o,
  alirs_cfg_if.sink  cfg_i
);
  import alirs_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic in_valid_q;
  logic req_q;
  logic sda_q;
  logic out_valid_q, out_valid_d;
  logic advance;
  logic in_fire;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  alirs_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  alirs_seq #(
    .WaitCounterBits (WaitCounterBits)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .req_i     (req_q),
    .sda_i     (sda_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_i.start_request;
      sda_q <= in_i.sda_level;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.clock_line      = res_q.clock_line;
  assign out_o.data_line_out   = res_q.data_line_out;
  assign out_o.data_line_input = res_q.data_line_input;
  assign out_o.busy_res        = res_q.busy_res;
  assign out_o.done_res        = res_q.done_res;
  assign out_o.raw_count       = res_q.raw_count;
  assign out_o.lux             = res_q.lux;

endmodule

`default_nettype wire

// File: src/alirs_checker.sv
// Port-level checks for the readout sequencer and the bind that attaches them.
`default_nettype none

module alirs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic clock_line,
  input wire logic data_line_out,
  input wire logic data_line_input,
  input wire logic busy_res,
  input wire logic done_res
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // The done flag only appears on the closing tick of a running sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && done_res |-> busy_res)
    else $error("done flagged outside a sequence");

  // A released data line always reads as a driven high level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && data_line_input |-> data_line_out)
    else $error("data line released but driven low");

  // When idle the bus rests with both lines high and nothing released.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !busy_res |-> clock_line && data_line_out && !data_line_input && !done_res)
    else $error("bus not at rest while idle");

endmodule

bind ambient_light_i2c_readout_sequencer alirs_checker u_alirs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .clock_line      (out_o.clock_line),
  .data_line_out   (out_o.data_line_out),
  .data_line_input (out_o.data_line_input),
  .busy_res        (out_o.busy_res),
  .done_res        (out_o.done_res)
);

`default_nettype wire

// File: dv/tb_ambient_light_i2c_readout_sequencer.sv
// Self-checking testbench for the ambient light sensor I2C readout sequencer.
`timescale 1ns / 1ps

module tb_ambient_light_i2c_readout_sequencer;
  import alirs_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned RandomTicks = 800;
  localparam int unsigned NumDirected = 20;

  localparam res_t IdleRes  = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0};
  localparam res_t BusyHiHi = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0};
  localparam res_t BusyHiLo = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0};
  localparam res_t BusyLoLo = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0};
  localparam res_t BusyLoHi = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0};

  typedef enum logic [3:0] {
    SqIdle, SqStartPwr, SqAddrPwr, SqPwrCmd, SqStopPwr,
    SqStartMode, SqAddrMode, SqModeCmd, SqStopMode, SqConvWait,
    SqStartRead, SqAddrRead, SqReadData, SqStopRead, SqReport
  } seq_phase_e;

  typedef struct {
    logic req;
    logic sda;
    bit   typed;
    res_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  alirs_in_if  tick_if ();
  alirs_out_if bus_if ();
  alirs_cfg_if reg_if ();

  ambient_light_i2c_readout_sequencer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .out_o  (bus_if),
    .cfg_i  (reg_if)
  );

  logic [ByteW-1:0] cfg_addr;
  logic [ByteW-1:0] cfg_pwr;
  logic [ByteW-1:0] cfg_mode;
  logic [WaitW-1:0] cfg_wait;

  seq_phase_e       ph;
  logic [3:0]       bit_cnt;
  logic             second_byte;
  logic             half;
  logic [ByteW-1:0] shreg;
  logic [WaitW-1:0] wait_left;
  logic [ByteW-1:0] hi_byte;
  logic [RawW-1:0]  raw_q;
  logic [RawW-1:0]  lux_q;

  res_t        tick_results_q [$];
  int unsigned mismatches;
  int unsigned ticks_sent;
  int unsigned cycle_cnt;
  bit          send_calm;
  bit          recv_calm;
  dir_row_t    dir_rows [NumDirected];

  function automatic void goto_phase(input seq_phase_e nx);
    ph = nx;
    bit_cnt = '0;
    half = 1'b0;
    case (nx)
      SqAddrPwr, SqAddrMode: shreg = cfg_addr;
      SqPwrCmd: shreg = cfg_pwr;
      SqModeCmd: shreg = cfg_mode;
      SqAddrRead: shreg = cfg_addr + 8'd1;
      SqReadData: begin
        shreg = '0;
        second_byte = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void end_two_tick(input seq_phase_e nx);
    if (!half) begin
      half = 1'b1;
    end else if (nx == SqConvWait) begin
      wait_left = cfg_wait;
      goto_phase((wait_left == '0) ? SqStartRead : SqConvWait);
    end else begin
      goto_phase(nx);
    end
  endfunction

  function automatic res_t predict_tick(input logic req, input logic sda);
    res_t       r;
    seq_phase_e nx;
    r = IdleRes;
    r.busy_res = 1'b1;
    if (ph == SqIdle && req) goto_phase(SqStartPwr);
    case (ph)
      SqIdle: r.busy_res = 1'b0;
      SqStartPwr, SqStartMode, SqStartRead: begin
        r.data_line_out = !half;
        nx = (ph == SqStartPwr) ? SqAddrPwr : (ph == SqStartMode) ? SqAddrMode : SqAddrRead;
        end_two_tick(nx);
      end
      SqStopPwr, SqStopMode, SqStopRead: begin
        r.data_line_out = half;
        nx = (ph == SqStopPwr) ? SqStartMode : (ph == SqStopMode) ? SqConvWait : SqReport;
        end_two_tick(nx);
      end
      SqAddrPwr, SqPwrCmd, SqAddrMode, SqModeCmd, SqAddrRead: begin
        r.clock_line = !half;
        if (bit_cnt < 4'd8) r.data_line_out = shreg[7];
        else r.data_line_input = 1'b1;
        if (!half) begin
          half = 1'b1;
        end else begin
          half = 1'b0;
          shreg = shreg << 1;
          bit_cnt++;
          if (bit_cnt > 4'd8) begin
            case (ph)
              SqAddrPwr:  nx = SqPwrCmd;
              SqPwrCmd:   nx = SqStopPwr;
              SqAddrMode: nx = SqModeCmd;
              SqModeCmd:  nx = SqStopMode;
              default:    nx = SqReadData;
            endcase
            goto_phase(nx);
          end
        end
      end
      SqConvWait: begin
        wait_left--;
        if (wait_left == '0) goto_phase(SqStartRead);
      end
      SqReadData: begin
        r.clock_line = !half;
        if (bit_cnt < 4'd8) begin
          r.data_line_input = 1'b1;
          if (!half) shreg = {shreg[6:0], sda};
        end else begin
          r.data_line_out = second_byte;
        end
        if (!half) begin
          half = 1'b1;
        end else begin
          half = 1'b0;
          bit_cnt++;
          if (bit_cnt > 4'd8) begin
            bit_cnt = '0;
            if (!second_byte) begin
              hi_byte = shreg;
              shreg = '0;
              second_byte = 1'b1;
            end else begin
              raw_q = {hi_byte, shreg};
              lux_q = 16'((32'(raw_q) * 32'd5) / 32'd6);
              second_byte = 1'b0;
              goto_phase(SqStopRead);
            end
          end
        end
      end
      SqReport: begin
        r.done_res = 1'b1;
        goto_phase(SqIdle);
      end
      default: begin
        r.busy_res = 1'b0;
        goto_phase(SqIdle);
      end
    endcase
    r.raw_count = raw_q;
    r.lux = lux_q;
    return r;
  endfunction

  function automatic int unsigned draw_gap(inout bit calm);
    if ($urandom_range(0, 47) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_tick(input logic req, input logic sda, input bit typed, input res_t want);
    int unsigned gap;
    res_t        pred;
    gap = draw_gap(send_calm);
    if (gap != 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_if.valid <= 1'b1;
    tick_if.start_request <= req;
    tick_if.sda_level <= sda;
    @(negedge clk_i);
    while (tick_if.ready !== 1'b1) @(negedge clk_i);
    pred = predict_tick(req, sda);
    tick_results_q.push_back(typed ? want : pred);
    ticks_sent++;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tick_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data <= value;
    @(negedge clk_i);
    while (reg_if.ready !== 1'b1) @(negedge clk_i);
    case (idx)
      CfgDevAddr: cfg_addr = value[ByteW-1:0];
      CfgPwrCmd:  cfg_pwr = value[ByteW-1:0];
      CfgModeCmd: cfg_mode = value[ByteW-1:0];
      CfgWait:    cfg_wait = value[WaitW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic run_measurement(input int unsigned sda_mode, input bit hold);
    int unsigned hold_at;
    int unsigned n;
    logic        sda;
    hold_at = $urandom_range(2, 150);
    n = 0;
    repeat ($urandom_range(0, 4)) send_tick(1'b0, 1'($urandom_range(0, 1)), 1'b0, '0);
    do begin
      if (hold && n == hold_at) drain_results();
      sda = (sda_mode == 0) ? 1'b0 : (sda_mode == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      send_tick((n == 0) ? 1'b1 : 1'($urandom_range(0, 1)), sda, 1'b0, '0);
      n++;
    end while (ph != SqIdle);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    bus_if.ready = 1'b0;
    recv_calm = 1'b0;
    @(posedge clk_i);
    forever begin
      int unsigned stall;
      res_t        want;
      stall = draw_gap(recv_calm);
      if (stall != 0) begin
        bus_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      bus_if.ready <= 1'b1;
      @(negedge clk_i);
      while (bus_if.valid !== 1'b1) @(negedge clk_i);
      if (tick_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual clk=%0b sda=%0b raw=%0h",
                 $time, bus_if.clock_line, bus_if.data_line_out, bus_if.raw_count);
        mismatches++;
      end else begin
        want = tick_results_q.pop_front();
        check_field("clock_line", want.clock_line, bus_if.clock_line);
        check_field("data_line_out", want.data_line_out, bus_if.data_line_out);
        check_field("data_line_input", want.data_line_input, bus_if.data_line_input);
        check_field("busy_res", want.busy_res, bus_if.busy_res);
        check_field("done_res", want.done_res, bus_if.done_res);
        check_field("raw_count", want.raw_count, bus_if.raw_count);
        check_field("lux", want.lux, bus_if.lux);
      end
      @(posedge clk_i);
    end
  end

  initial begin
    int unsigned base;
    int unsigned phase_no;
    rst_ni = 1'b0;
    tick_if.valid = 1'b0;
    tick_if.start_request = 1'b0;
    tick_if.sda_level = 1'b0;
    reg_if.valid = 1'b0;
    reg_if.index = CfgDevAddr;
    reg_if.data = '0;
    mismatches = 0;
    ticks_sent = 0;
    send_calm = 1'b0;
    cfg_addr = DevAddrRst;
    cfg_pwr = PwrCmdRst;
    cfg_mode = ModeCmdRst;
    cfg_wait = WaitRst;
    ph = SqIdle;
    bit_cnt = '0;
    second_byte = 1'b0;
    half = 1'b0;
    shreg = '0;
    wait_left = '0;
    hi_byte = '0;
    raw_q = '0;
    lux_q = '0;

    // With the reset address 0x46 the first address bits are 0 then 1.
    dir_rows = '{
      '{1'b0, 1'b0, 1'b1, IdleRes},
      '{1'b0, 1'b1, 1'b1, IdleRes},
      '{1'b0, 1'b1, 1'b1, IdleRes},
      '{1'b1, 1'b0, 1'b1, BusyHiHi},
      '{1'b1, 1'b1, 1'b1, BusyHiLo},
      '{1'b0, 1'b0, 1'b1, BusyHiLo},
      '{1'b1, 1'b1, 1'b1, BusyLoLo},
      '{1'b0, 1'b1, 1'b1, BusyHiHi},
      '{1'b1, 1'b0, 1'b1, BusyLoHi},
      '{1'b1, 1'b1, 1'b0, IdleRes},
      '{1'b0, 1'b0, 1'b0, IdleRes},
      '{1'b1, 1'b0, 1'b0, IdleRes},
      '{1'b0, 1'b1, 1'b0, IdleRes},
      '{1'b1, 1'b1, 1'b0, IdleRes},
      '{1'b0, 1'b0, 1'b0, IdleRes},
      '{1'b1, 1'b0, 1'b0, IdleRes},
      '{1'b0, 1'b1, 1'b0, IdleRes},
      '{1'b1, 1'b1, 1'b0, IdleRes},
      '{1'b0, 1'b0, 1'b0, IdleRes},
      '{1'b1, 1'b1, 1'b0, IdleRes}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first measurement uses the reset address and commands with a short wait.
    write_reg(CfgWait, 20'd40);
    reg_if.valid <= 1'b0;

    foreach (dir_rows[i]) begin
      send_tick(dir_rows[i].req, dir_rows[i].sda, dir_rows[i].typed, dir_rows[i].want);
    end
    while (ph != SqIdle) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);

    base = ticks_sent;
    phase_no = 0;
    while (ticks_sent - base < RandomTicks) begin
      drain_results();
      case (phase_no)
        0: begin
          write_reg(CfgDevAddr, 20'd0);
          write_reg(CfgPwrCmd, 20'd0);
          write_reg(CfgModeCmd, 20'd0);
          write_reg(CfgWait, 20'd0);
        end
        1: begin
          write_reg(CfgDevAddr, 20'd255);
          write_reg(CfgPwrCmd, 20'd255);
          write_reg(CfgModeCmd, 20'd255);
          write_reg(CfgWait, 20'd1);
        end
        2: begin
          write_reg(CfgWait, 20'hFFFFF);
          write_reg(CfgDevAddr, 20'd254);
          write_reg(CfgPwrCmd, 20'hA5);
          write_reg(CfgModeCmd, 20'h5A);
          write_reg(CfgWait, 20'd2);
        end
        default: begin
          write_reg(CfgDevAddr, 20'($urandom_range(0, 255)));
          write_reg(CfgPwrCmd, 20'($urandom_range(0, 255)));
          write_reg(CfgModeCmd, 20'($urandom_range(0, 255)));
          write_reg(CfgWait, ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 300))
                                                         : 20'($urandom_range(0, 12)));
        end
      endcase
      reg_if.valid <= 1'b0;
      run_measurement((phase_no < 2) ? phase_no : $urandom_range(0, 3),
                      phase_no == 3 || $urandom_range(0, 3) == 0);
      phase_no++;
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && tick_results_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
src/alirs_pkg.sv
src/alirs_if.sv
src/alirs_cfg_regs.sv
src/alirs_lux.sv
src/alirs_seq.sv
src/ambient_light_i2c_readout_sequencer.sv
src/alirs_checker.sv
dv/tb_ambient_light_i2c_readout_sequencer.sv
